// ===== sv/rvc_pkg.sv =====
// Shared types, constants and helpers for the ray against upright cylinder block.
// Depends on nothing; the divider and the top level use it by scoped names.
package rvc_pkg;

    localparam int FRAC = 16;
    localparam int QW   = FRAC + 1;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [31:0] s;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cb;
        logic        [30:0] r;
        logic        [30:0] h;
    } ray_t;

    typedef struct packed {
        logic        hit;
        logic [34:0] pq;
        ray_t        ray;
    } pl1_t;

    typedef struct packed {
        logic               hit;
        logic        [30:0] distance;
        logic signed [31:0] hx;
        logic signed [31:0] hy;
        logic signed [31:0] hz;
        logic               sx;
        logic               sy;
    } res_t;

    typedef struct packed {
        res_t        res;
        logic [30:0] ax;
        logic [30:0] ay;
    } pl2_t;

    typedef struct packed {
        res_t res;
        logic lz;
    } pl3_t;

    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        logic signed [31:0] o;
        if (v > 53'sd2147483647)
        begin
            o = 32'sh7FFF_FFFF;
        end
        else if (v < -53'sd2147483648)
        begin
            o = 32'sh8000_0000;
        end
        else
        begin
            o = $signed(v[31:0]);
        end
        return o;
    endfunction

endpackage

// ===== sv/rvc_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a payload carried alongside.
// Depends on nothing beyond its parameters.
module rvc_isqrt #(
    parameter int W  = 64,
    parameter int PW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [W-1:0]     in_value,
    input  logic [PW-1:0]    in_pl,
    output logic             out_valid,
    output logic [W/2-1:0]   out_root,
    output logic [PW-1:0]    out_pl
);
    localparam int STEPS = W / 2;

    logic [STEPS-1:0] vld_reg;
    logic [W-1:0]     rem_reg  [STEPS];
    logic [W-1:0]     root_reg [STEPS];
    logic [PW-1:0]    pl_reg   [STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
        logic [W-1:0]  rem_i;
        logic [W-1:0]  root_i;
        logic [W-1:0]  rem_next;
        logic [W-1:0]  root_next;
        logic [PW-1:0] pl_i;
        logic [W:0]    trial;
        logic          ge;
        if (k == 0)
        begin : g_head
            assign rem_i  = in_value;
            assign root_i = '0;
            assign pl_i   = in_pl;
        end
        else
        begin : g_tail
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign pl_i   = pl_reg[k-1];
        end
        assign trial     = {1'b0, root_i} + {1'b0, BIT};
        assign ge        = {1'b0, rem_i} >= trial;
        assign rem_next  = ge ? rem_i - trial[W-1:0] : rem_i;
        assign root_next = ge ? (root_i >> 1) + BIT : (root_i >> 1);
        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            pl_reg[k]   <= pl_i;
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1][STEPS-1:0];
    assign out_pl    = pl_reg[STEPS-1];

    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((root_reg[STEPS-1] >> STEPS) == '0))
        else $error("square root wider than half the operand");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, rem_reg[STEPS-1]} <= {root_reg[STEPS-1], 1'b0}))
        else $error("square root remainder exceeds twice the root");

endmodule

// ===== sv/rvc_udiv.sv =====
// Two-lane pipelined restoring divider forming (num << FRAC) / den, one quotient bit per stage.
// Depends on rvc_pkg for the quotient width (FRAC + 1); the numerator must not exceed den.
module rvc_udiv #(
    parameter int NW = 31,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [NW-1:0]          in_num_x,
    input  logic [NW-1:0]          in_num_y,
    input  logic [DW-1:0]          in_den,
    input  logic [PW-1:0]          in_pl,
    output logic                   out_valid,
    output logic [rvc_pkg::QW-1:0] out_quo_x,
    output logic [rvc_pkg::QW-1:0] out_quo_y,
    output logic [PW-1:0]          out_pl
);
    localparam int QW = rvc_pkg::QW;

    logic [QW-1:0] vld_reg;
    logic [DW-1:0] rx_reg  [QW];
    logic [DW-1:0] ry_reg  [QW];
    logic [QW-1:0] qx_reg  [QW];
    logic [QW-1:0] qy_reg  [QW];
    logic [DW-1:0] den_reg [QW];
    logic [PW-1:0] pl_reg  [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QW-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW-1:0] rx_i;
        logic [DW-1:0] ry_i;
        logic [QW-1:0] qx_i;
        logic [QW-1:0] qy_i;
        logic [DW-1:0] den_i;
        logic [PW-1:0] pl_i;
        logic          bx;
        logic          by;
        logic [DW:0]   tx;
        logic [DW:0]   ty;
        logic          gx;
        logic          gy;
        if (k == 0)
        begin : g_head
            assign rx_i  = DW'(in_num_x >> 1);
            assign ry_i  = DW'(in_num_y >> 1);
            assign qx_i  = '0;
            assign qy_i  = '0;
            assign den_i = in_den;
            assign pl_i  = in_pl;
            assign bx    = in_num_x[0];
            assign by    = in_num_y[0];
        end
        else
        begin : g_tail
            assign rx_i  = rx_reg[k-1];
            assign ry_i  = ry_reg[k-1];
            assign qx_i  = qx_reg[k-1];
            assign qy_i  = qy_reg[k-1];
            assign den_i = den_reg[k-1];
            assign pl_i  = pl_reg[k-1];
            assign bx    = 1'b0;
            assign by    = 1'b0;
        end
        assign tx = {rx_i, bx};
        assign ty = {ry_i, by};
        assign gx = tx >= {1'b0, den_i};
        assign gy = ty >= {1'b0, den_i};
        always_ff @(posedge clk)
        begin
            rx_reg[k]  <= gx ? DW'(tx - {1'b0, den_i}) : tx[DW-1:0];
            ry_reg[k]  <= gy ? DW'(ty - {1'b0, den_i}) : ty[DW-1:0];
            qx_reg[k]  <= {qx_i[QW-2:0], gx};
            qy_reg[k]  <= {qy_i[QW-2:0], gy};
            den_reg[k] <= den_i;
            pl_reg[k]  <= pl_i;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo_x = qx_reg[QW-1];
    assign out_quo_y = qy_reg[QW-1];
    assign out_pl    = pl_reg[QW-1];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (den_reg[QW-1] != '0)
        |-> (rx_reg[QW-1] < den_reg[QW-1]) && (ry_reg[QW-1] < den_reg[QW-1]))
        else $error("divider remainder not below divisor");

endmodule

// ===== sv/ray_vertical_cylinder_intersect_top.sv =====
// Top level of the ray against upright cylinder intersection pipeline.
// Depends on rvc_pkg, rvc_isqrt and rvc_udiv.
//
//  channel  | direction | signals                                  | beat taken when
//  ---------+-----------+------------------------------------------+------------------
//  request  | in        | start, ray_*, cyl_*                      | start high, busy low
//  result   | out       | done, hit_flag, hit_*, normal_*          | done high
//
// One beat is accepted every cycle; busy stays low.
// Each result passes through 7 front stages,
// a 31-stage half-chord root, 7 stages for the entry point, a 32-stage length root,
// 17 divider stages and the output register.
// Reset clears only the valid bits; the receiver cannot stall, so nothing ever waits.
module ray_vertical_cylinder_intersect_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] ray_origin_x,
    input  logic signed [31:0] ray_origin_y,
    input  logic signed [31:0] ray_origin_height,
    input  logic signed [17:0] ray_dir_x,
    input  logic signed [17:0] ray_dir_y,
    input  logic signed [31:0] ray_slope,
    input  logic signed [31:0] cyl_center_x,
    input  logic signed [31:0] cyl_center_y,
    input  logic signed [31:0] cyl_base,
    input  logic        [30:0] cyl_radius,
    input  logic        [30:0] cyl_height,
    output logic               done,
    output logic               hit_flag,
    output logic        [30:0] hit_distance,
    output logic signed [31:0] hit_x,
    output logic signed [31:0] hit_y,
    output logic signed [31:0] hit_height,
    output logic signed [17:0] normal_x,
    output logic signed [17:0] normal_y
);
    rvc_pkg::ray_t ray_in;
    logic          accept;

    logic [6:0] fv_reg;
    logic [6:0] bv_reg;

    rvc_pkg::ray_t      ray1_reg, ray2_reg, ray3_reg, ray4_reg, ray5_reg, ray6_reg, ray7_reg;
    logic signed [32:0] tx1_reg, ty1_reg, tx2_reg, ty2_reg, tx3_reg, ty3_reg, tx4_reg, ty4_reg;
    logic signed [50:0] px2_reg, py2_reg;
    logic signed [51:0] pw3;
    logic               hit3_reg, hit4_reg, hit5_reg, hit6_reg, hit7_reg;
    logic        [34:0] pq3_reg, pq4_reg, pq5_reg, pq6_reg, pq7_reg;
    logic signed [53:0] pdx4_reg, pdy4_reg;
    logic signed [67:0] ps4_reg;
    logic signed [38:0] ex5, ey5;
    logic        [38:0] aex5, aey5;
    logic signed [52:0] z5, zlo5, zhi5;
    logic               hit5_next;
    logic        [30:0] ax5_reg, ay5_reg;
    logic        [61:0] sqx6_reg, sqy6_reg, r2_6_reg;
    logic        [62:0] d2_7;
    logic        [61:0] diff7_reg;

    rvc_pkg::pl1_t sq1_in_pl, sq1_pl;
    logic          sq1_valid;
    logic [30:0]   sq1_root;

    rvc_pkg::pl1_t      pla_reg, plb_reg;
    logic        [34:0] hda_next, hda_reg, hdb_reg;
    logic signed [53:0] pdxb_reg, pdyb_reg;
    logic signed [67:0] psb_reg;
    logic signed [38:0] hxc_reg, hyc_reg;
    logic signed [52:0] hzc_reg;
    logic        [30:0] distc_reg;
    logic               hitc_reg;
    logic signed [31:0] cxc_reg, cyc_reg;
    logic signed [39:0] nxd, nyd;
    logic        [39:0] anxd_reg, anyd_reg;
    rvc_pkg::res_t      resd_reg, rese_reg, resf_reg;
    logic        [39:0] mag_e;
    logic        [3:0]  sh_e;
    logic        [30:0] axe_reg, aye_reg, axf_reg, ayf_reg;
    logic        [61:0] sqxf_reg, sqyf_reg;
    logic        [62:0] sumg_reg;
    rvc_pkg::pl2_t      plg_reg;

    rvc_pkg::pl2_t sq2_pl;
    logic          sq2_valid;
    logic [31:0]   sq2_root;
    rvc_pkg::pl3_t div_in_pl, div_pl;
    logic          div_valid;
    logic [rvc_pkg::QW-1:0] div_qx, div_qy;

    logic               done_reg, hit_flag_reg, hit_flag_next;
    logic        [30:0] hit_distance_reg, hit_distance_next;
    logic signed [31:0] hit_x_reg, hit_y_reg, hit_height_reg;
    logic signed [31:0] hit_x_next, hit_y_next, hit_height_next;
    logic signed [17:0] normal_x_reg, normal_y_reg, normal_x_next, normal_y_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_comb
    begin
        ray_in.ox = ray_origin_x;
        ray_in.oy = ray_origin_y;
        ray_in.oz = ray_origin_height;
        ray_in.dx = ray_dir_x;
        ray_in.dy = ray_dir_y;
        ray_in.s  = ray_slope;
        ray_in.cx = cyl_center_x;
        ray_in.cy = cyl_center_y;
        ray_in.cb = cyl_base;
        ray_in.r  = cyl_radius;
        ray_in.h  = cyl_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg   <= '0;
            bv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fv_reg   <= {fv_reg[5:0], accept};
            bv_reg   <= {bv_reg[5:0], sq1_valid};
            done_reg <= div_valid;
        end
    end

    // Projection of the centre onto the ray and the rejection tests.
    assign pw3 = 52'(px2_reg) + 52'(py2_reg);

    always_comb
    begin
        ex5  = 39'(tx4_reg) - 39'($signed(pdx4_reg[53:16]));
        ey5  = 39'(ty4_reg) - 39'($signed(pdy4_reg[53:16]));
        aex5 = ex5[38] ? 39'(-ex5) : 39'(ex5);
        aey5 = ey5[38] ? 39'(-ey5) : 39'(ey5);
        z5   = 53'(ray4_reg.oz) + 53'($signed(ps4_reg[67:16]));
        zlo5 = 53'(ray4_reg.cb);
        zhi5 = 53'(ray4_reg.cb) + $signed(53'(ray4_reg.h));
        hit5_next = hit4_reg && (aex5 <= 39'(ray4_reg.r)) && (aey5 <= 39'(ray4_reg.r))
                    && (z5 >= zlo5) && (z5 <= zhi5);
    end

    assign d2_7 = 63'(sqx6_reg) + 63'(sqy6_reg);

    always_ff @(posedge clk)
    begin
        ray1_reg  <= ray_in;
        tx1_reg   <= 33'(cyl_center_x) - 33'(ray_origin_x);
        ty1_reg   <= 33'(cyl_center_y) - 33'(ray_origin_y);

        ray2_reg  <= ray1_reg;
        tx2_reg   <= tx1_reg;
        ty2_reg   <= ty1_reg;
        px2_reg   <= 51'(tx1_reg) * 51'(ray1_reg.dx);
        py2_reg   <= 51'(ty1_reg) * 51'(ray1_reg.dy);

        ray3_reg  <= ray2_reg;
        tx3_reg   <= tx2_reg;
        ty3_reg   <= ty2_reg;
        hit3_reg  <= ~pw3[51];
        pq3_reg   <= pw3[50:16];

        ray4_reg  <= ray3_reg;
        tx4_reg   <= tx3_reg;
        ty4_reg   <= ty3_reg;
        hit4_reg  <= hit3_reg;
        pq4_reg   <= pq3_reg;
        pdx4_reg  <= 54'(ray3_reg.dx) * 54'($signed({1'b0, pq3_reg}));
        pdy4_reg  <= 54'(ray3_reg.dy) * 54'($signed({1'b0, pq3_reg}));
        ps4_reg   <= 68'(ray3_reg.s) * 68'($signed({1'b0, pq3_reg}));

        ray5_reg  <= ray4_reg;
        pq5_reg   <= pq4_reg;
        hit5_reg  <= hit5_next;
        ax5_reg   <= aex5[30:0];
        ay5_reg   <= aey5[30:0];

        ray6_reg  <= ray5_reg;
        pq6_reg   <= pq5_reg;
        hit6_reg  <= hit5_reg;
        sqx6_reg  <= 62'(ax5_reg) * 62'(ax5_reg);
        sqy6_reg  <= 62'(ay5_reg) * 62'(ay5_reg);
        r2_6_reg  <= 62'(ray5_reg.r) * 62'(ray5_reg.r);

        ray7_reg  <= ray6_reg;
        pq7_reg   <= pq6_reg;
        hit7_reg  <= hit6_reg && (d2_7 <= 63'(r2_6_reg));
        diff7_reg <= r2_6_reg - d2_7[61:0];
    end

    always_comb
    begin
        sq1_in_pl.hit = hit7_reg;
        sq1_in_pl.pq  = pq7_reg;
        sq1_in_pl.ray = ray7_reg;
    end

    rvc_isqrt #(
        .W  (62),
        .PW ($bits(rvc_pkg::pl1_t))
    ) u_chord_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv_reg[6]),
        .in_value  (diff7_reg),
        .in_pl     (sq1_in_pl),
        .out_valid (sq1_valid),
        .out_root  (sq1_root),
        .out_pl    (sq1_pl)
    );

    // Entry distance, entry point and the vector from the centre to it.
    assign hda_next = (sq1_pl.pq < 35'(sq1_root)) ? '0 : sq1_pl.pq - 35'(sq1_root);

    always_comb
    begin
        nxd = 40'(hxc_reg) - 40'(cxc_reg);
        nyd = 40'(hyc_reg) - 40'(cyc_reg);
        mag_e = anxd_reg | anyd_reg;
        sh_e = '0;
        for (int i = 1; i <= 9; i++)
        begin
            if (mag_e[30+i])
            begin
                sh_e = 4'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pla_reg   <= sq1_pl;
        hda_reg   <= hda_next;

        plb_reg   <= pla_reg;
        hdb_reg   <= hda_reg;
        pdxb_reg  <= 54'(pla_reg.ray.dx) * 54'($signed({1'b0, hda_reg}));
        pdyb_reg  <= 54'(pla_reg.ray.dy) * 54'($signed({1'b0, hda_reg}));
        psb_reg   <= 68'(pla_reg.ray.s) * 68'($signed({1'b0, hda_reg}));

        hxc_reg   <= 39'(plb_reg.ray.ox) + 39'($signed(pdxb_reg[53:16]));
        hyc_reg   <= 39'(plb_reg.ray.oy) + 39'($signed(pdyb_reg[53:16]));
        hzc_reg   <= 53'(plb_reg.ray.oz) + 53'($signed(psb_reg[67:16]));
        distc_reg <= (hdb_reg > 35'h7FFF_FFFF) ? 31'h7FFF_FFFF : hdb_reg[30:0];
        hitc_reg  <= plb_reg.hit;
        cxc_reg   <= plb_reg.ray.cx;
        cyc_reg   <= plb_reg.ray.cy;

        anxd_reg          <= nxd[39] ? 40'(-nxd) : 40'(nxd);
        anyd_reg          <= nyd[39] ? 40'(-nyd) : 40'(nyd);
        resd_reg.hit      <= hitc_reg;
        resd_reg.distance <= distc_reg;
        resd_reg.hx       <= rvc_pkg::sat32(53'(hxc_reg));
        resd_reg.hy       <= rvc_pkg::sat32(53'(hyc_reg));
        resd_reg.hz       <= rvc_pkg::sat32(hzc_reg);
        resd_reg.sx       <= nxd[39];
        resd_reg.sy       <= nyd[39];

        rese_reg  <= resd_reg;
        axe_reg   <= 31'(anxd_reg >> sh_e);
        aye_reg   <= 31'(anyd_reg >> sh_e);

        resf_reg  <= rese_reg;
        axf_reg   <= axe_reg;
        ayf_reg   <= aye_reg;
        sqxf_reg  <= 62'(axe_reg) * 62'(axe_reg);
        sqyf_reg  <= 62'(aye_reg) * 62'(aye_reg);

        sumg_reg     <= 63'(sqxf_reg) + 63'(sqyf_reg);
        plg_reg.res  <= resf_reg;
        plg_reg.ax   <= axf_reg;
        plg_reg.ay   <= ayf_reg;
    end

    rvc_isqrt #(
        .W  (64),
        .PW ($bits(rvc_pkg::pl2_t))
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bv_reg[6]),
        .in_value  ({1'b0, sumg_reg}),
        .in_pl     (plg_reg),
        .out_valid (sq2_valid),
        .out_root  (sq2_root),
        .out_pl    (sq2_pl)
    );

    always_comb
    begin
        div_in_pl.res = sq2_pl.res;
        div_in_pl.lz  = (sq2_root == '0);
    end

    rvc_udiv #(
        .NW (31),
        .DW (32),
        .PW ($bits(rvc_pkg::pl3_t))
    ) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq2_valid),
        .in_num_x  (sq2_pl.ax),
        .in_num_y  (sq2_pl.ay),
        .in_den    (sq2_root),
        .in_pl     (div_in_pl),
        .out_valid (div_valid),
        .out_quo_x (div_qx),
        .out_quo_y (div_qy),
        .out_pl    (div_pl)
    );

    always_comb
    begin
        hit_flag_next     = 1'b0;
        hit_distance_next = '0;
        hit_x_next        = '0;
        hit_y_next        = '0;
        hit_height_next   = '0;
        normal_x_next     = '0;
        normal_y_next     = '0;
        if (div_pl.res.hit)
        begin
            hit_flag_next     = 1'b1;
            hit_distance_next = div_pl.res.distance;
            hit_x_next        = div_pl.res.hx;
            hit_y_next        = div_pl.res.hy;
            hit_height_next   = div_pl.res.hz;
            if (!div_pl.lz)
            begin
                normal_x_next = div_pl.res.sx ? 18'(-$signed({1'b0, div_qx}))
                                              : $signed({1'b0, div_qx});
                normal_y_next = div_pl.res.sy ? 18'(-$signed({1'b0, div_qy}))
                                              : $signed({1'b0, div_qy});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_flag_reg     <= hit_flag_next;
        hit_distance_reg <= hit_distance_next;
        hit_x_reg        <= hit_x_next;
        hit_y_reg        <= hit_y_next;
        hit_height_reg   <= hit_height_next;
        normal_x_reg     <= normal_x_next;
        normal_y_reg     <= normal_y_next;
    end

    assign done         = done_reg;
    assign hit_flag     = hit_flag_reg;
    assign hit_distance = hit_distance_reg;
    assign hit_x        = hit_x_reg;
    assign hit_y        = hit_y_reg;
    assign hit_height   = hit_height_reg;
    assign normal_x     = normal_x_reg;
    assign normal_y     = normal_y_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit_flag |-> (hit_distance == '0) && (hit_x == '0) && (hit_y == '0)
                              && (hit_height == '0) && (normal_x == '0) && (normal_y == '0))
        else $error("missed beat carries non-zero fields");

    a_normal_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (normal_x <= 18'sd65536) && (normal_x >= -18'sd65536)
                 && (normal_y <= 18'sd65536) && (normal_y >= -18'sd65536))
        else $error("normal component beyond unit length");

endmodule
